[rtl/fabs_pkg.sv]
// fabs_pkg: constants, types and pixel format helpers for the framebuffer blend store
// no dependencies; used by the interfaces and the top level
package fabs_pkg;

  localparam int SCREEN_COLS = 480;
  localparam int SCREEN_ROWS = 272;
  localparam int MAX_STRIDE  = 512;

  localparam int STORE_DEPTH = MAX_STRIDE * SCREEN_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(SCREEN_COLS);
  localparam int ROW_W       = $clog2(SCREEN_ROWS);
  localparam int STRIDE_W    = 10;
  localparam int PROD_W      = ROW_W + STRIDE_W;
  localparam int COORD_W     = 11;
  localparam int WORD_W      = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(MAX_STRIDE);

  typedef enum logic [1:0] {
    FMT_RGB565   = 2'd0,
    FMT_RGB5551  = 2'd1,
    FMT_RGB4444  = 2'd2,
    FMT_ABGR8888 = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    ACT_BLEND = 2'd0,
    ACT_RAW   = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_FORMAT = 1'b0,
    CFG_LINE_STRIDE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgb_t;

  typedef struct packed {
    logic [15:0] b;
    logic [15:0] g;
    logic [15:0] r;
  } mix_t;

  function automatic logic [WORD_W-1:0] fmt_mask(input fmt_e fmt);
    return (fmt == FMT_ABGR8888) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
  endfunction

  function automatic rgb_t expand(input logic [WORD_W-1:0] w, input fmt_e fmt);
    rgb_t c;
    case (fmt)
      FMT_RGB565: begin
        c.b = {w[15:11], 3'd0};
        c.g = {w[10:5], 2'd0};
        c.r = {w[4:0], 3'd0};
      end
      FMT_RGB5551: begin
        c.b = {w[14:10], 3'd0};
        c.g = {w[9:5], 3'd0};
        c.r = {w[4:0], 3'd0};
      end
      FMT_RGB4444: begin
        c.b = {w[11:8], 4'd0};
        c.g = {w[7:4], 4'd0};
        c.r = {w[3:0], 4'd0};
      end
      default: begin
        c.b = w[23:16];
        c.g = w[15:8];
        c.r = w[7:0];
      end
    endcase
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] pack(input rgb_t c, input fmt_e fmt);
    logic [WORD_W-1:0] w;
    case (fmt)
      FMT_RGB565:  w = {16'd0, c.b[7:3], c.g[7:2], c.r[7:3]};
      FMT_RGB5551: w = {17'd0, c.b[7:3], c.g[7:3], c.r[7:3]};
      FMT_RGB4444: w = {20'd0, c.b[7:4], c.g[7:4], c.r[7:4]};
      default:     w = {8'd0, c.b, c.g, c.r};
    endcase
    return w;
  endfunction

  // exact floor(v / 255) for v up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [15:0] mix(input logic [7:0] a, input logic [7:0] s,
                                      input logic [7:0] d);
    logic [15:0] ps;
    logic [15:0] pd;
    ps = {8'd0, a} * {8'd0, s};
    pd = {8'd0, 8'hFF - a} * {8'd0, d};
    return ps + pd;
  endfunction

endpackage

[rtl/fabs_if.sv]
// fabs_req_if and fabs_rsp_if: valid/ready channels of the framebuffer blend store
// depends on fabs_pkg for field widths
interface fabs_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            action;
  logic signed [fabs_pkg::COORD_W-1:0]   pos_x;
  logic signed [fabs_pkg::COORD_W-1:0]   pos_y;
  logic [fabs_pkg::WORD_W-1:0]           src_color;
  logic [fabs_pkg::WORD_W-1:0]           raw_pixel;

  modport source (output valid, action, pos_x, pos_y, src_color, raw_pixel, input ready);
  modport sink (input valid, action, pos_x, pos_y, src_color, raw_pixel, output ready);
endinterface

interface fabs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [fabs_pkg::WORD_W-1:0] pixel_word;
  logic                        in_bounds;
  logic                        was_written;

  modport source (output valid, pixel_word, in_bounds, was_written, input ready);
  modport sink (input valid, pixel_word, in_bounds, was_written, output ready);
endinterface

[rtl/framebuffer_alpha_blend_store.sv]
// framebuffer_alpha_blend_store: pixel store with source-over alpha blending
// depends on fabs_pkg and the channel interfaces in fabs_if.sv
//
//   channel   dir  handshake      word
//   req_i     in   valid/ready    action, pos_x, pos_y, src_color, raw_pixel
//   rsp_o     out  valid/ready    pixel_word, in_bounds, was_written
//   cfg_*     in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// each word steps through accept and address multiply, memory read, channel
// products, then divide, pack, write back and result register.
// one word is in flight at a time, so a write lands before the next read.
// the write-back cycle waits while an earlier result has not been taken.
// reset sets format abgr8888 and stride 512; the store itself is not cleared.
module framebuffer_alpha_blend_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fabs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fabs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fabs_req_if.sink                        req_i,
  fabs_rsp_if.source                      rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_MIX   = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  state_e                               state_q, state_d;
  fabs_pkg::fmt_e                       fmt_q;
  logic [fabs_pkg::STRIDE_W-1:0]        stride_q;
  logic [fabs_pkg::STRIDE_W-1:0]        stride_sat;

  logic [1:0]                           action_q;
  logic [fabs_pkg::WORD_W-1:0]          src_q;
  logic [fabs_pkg::WORD_W-1:0]          raw_q;
  logic                                 inb_q;
  logic [fabs_pkg::ADDR_W-1:0]          addr_q;
  logic [fabs_pkg::WORD_W-1:0]          rdata_q;
  fabs_pkg::mix_t                       mix_q;

  logic                                 out_valid_q;
  logic [fabs_pkg::WORD_W-1:0]          out_word_q;
  logic                                 out_inb_q;
  logic                                 out_wr_q;

  logic [fabs_pkg::WORD_W-1:0]          mem [fabs_pkg::STORE_DEPTH];

  logic                                 req_fire;
  logic                                 wb_fire;
  logic                                 x_in, y_in;
  logic [fabs_pkg::PROD_W-1:0]          addr_sum;
  logic [fabs_pkg::WORD_W-1:0]          mask;
  logic [fabs_pkg::WORD_W-1:0]          old_word;
  fabs_pkg::rgb_t                       dst_rgb;
  fabs_pkg::rgb_t                       src_rgb;
  fabs_pkg::rgb_t                       blend_rgb;
  logic [7:0]                           alpha;
  logic [fabs_pkg::WORD_W-1:0]          new_word;
  logic                                 wr_en;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign wb_fire     = (state_q == S_WRITE) && (!out_valid_q || rsp_o.ready);

  assign stride_sat = (stride_q > fabs_pkg::STRIDE_RESET) ? fabs_pkg::STRIDE_RESET : stride_q;

  assign x_in = !req_i.pos_x[fabs_pkg::COORD_W-1] &&
                ({1'b0, req_i.pos_x[fabs_pkg::COORD_W-2:0]} <
                 fabs_pkg::COORD_W'(fabs_pkg::SCREEN_COLS));
  assign y_in = !req_i.pos_y[fabs_pkg::COORD_W-1] &&
                ({1'b0, req_i.pos_y[fabs_pkg::COORD_W-2:0]} <
                 fabs_pkg::COORD_W'(fabs_pkg::SCREEN_ROWS));
  assign addr_sum = fabs_pkg::PROD_W'(req_i.pos_y[fabs_pkg::ROW_W-1:0]) *
                    fabs_pkg::PROD_W'(stride_sat) +
                    fabs_pkg::PROD_W'(req_i.pos_x[fabs_pkg::COL_W-1:0]);

  assign mask     = fabs_pkg::fmt_mask(fmt_q);
  assign old_word = rdata_q & mask;
  assign dst_rgb  = fabs_pkg::expand(old_word, fmt_q);
  assign alpha    = src_q[31:24];
  assign src_rgb  = src_q[23:0];

  assign blend_rgb.b = fabs_pkg::div255(mix_q.b);
  assign blend_rgb.g = fabs_pkg::div255(mix_q.g);
  assign blend_rgb.r = fabs_pkg::div255(mix_q.r);

  always_comb begin
    new_word = old_word;
    wr_en    = 1'b0;
    case (action_q)
      fabs_pkg::ACT_BLEND: begin
        if (alpha == 8'hFF) begin
          new_word = fabs_pkg::pack(src_rgb, fmt_q);
          wr_en    = 1'b1;
        end else if (alpha != 8'h00) begin
          new_word = fabs_pkg::pack(blend_rgb, fmt_q);
          wr_en    = 1'b1;
        end
      end
      fabs_pkg::ACT_RAW: begin
        new_word = raw_q & mask;
        wr_en    = 1'b1;
      end
      default: begin
        new_word = old_word;
      end
    endcase
    if (!inb_q) begin
      new_word = '0;
      wr_en    = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (req_fire) state_d = S_READ;
      S_READ:  state_d = S_MIX;
      S_MIX:   state_d = S_WRITE;
      S_WRITE: if (wb_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fmt_q       <= fabs_pkg::FMT_ABGR8888;
      stride_q    <= fabs_pkg::STRIDE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fabs_pkg::CFG_PIXEL_FORMAT: fmt_q <= fabs_pkg::fmt_e'(cfg_data_i[1:0]);
          fabs_pkg::CFG_LINE_STRIDE:  stride_q <= cfg_data_i[fabs_pkg::STRIDE_W-1:0];
          default: ;
        endcase
      end
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      action_q <= req_i.action;
      src_q    <= req_i.src_color;
      raw_q    <= req_i.raw_pixel;
      inb_q    <= x_in && y_in;
      addr_q   <= fabs_pkg::ADDR_W'(addr_sum);
    end
    if (state_q == S_MIX) begin
      mix_q.b <= fabs_pkg::mix(alpha, src_rgb.b, dst_rgb.b);
      mix_q.g <= fabs_pkg::mix(alpha, src_rgb.g, dst_rgb.g);
      mix_q.r <= fabs_pkg::mix(alpha, src_rgb.r, dst_rgb.r);
    end
    if (wb_fire) begin
      out_word_q <= new_word & mask;
      out_inb_q  <= inb_q;
      out_wr_q   <= wr_en;
    end
  end

  // frame store, one read and one write port
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      rdata_q <= mem[addr_q];
    end
    if (wb_fire && wr_en) begin
      mem[addr_q] <= new_word;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pixel_word  = out_word_q;
  assign rsp_o.in_bounds   = out_inb_q;
  assign rsp_o.was_written = out_wr_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == S_READ))
    else $error("accepted word did not start a read");

  a_wb_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_fire |=> (state_q == S_IDLE) && out_valid_q)
    else $error("write-back did not produce a result");

  a_oob_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.in_bounds) |-> (rsp_o.pixel_word == '0) && !rsp_o.was_written)
    else $error("out of screen access gave data or a write");

  a_narrow_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb_fire && (fmt_q != fabs_pkg::FMT_ABGR8888)) |-> (new_word[31:16] == 16'd0))
    else $error("16-bit format word has upper bits set");
`endif

endmodule

[verif/tb_framebuffer_alpha_blend_store.sv]
`timescale 1ns / 1ps
// tb_framebuffer_alpha_blend_store: self-checking bench for the framebuffer blend store,
// with a shadow store and blend predictor, directed rows, then random phases per format
// depends on fabs_pkg, the channel interfaces in fabs_if.sv and the top level
module tb_framebuffer_alpha_blend_store;

  localparam logic [1:0] ACT_BLEND = fabs_pkg::ACT_BLEND;
  localparam logic [1:0] ACT_RAW   = fabs_pkg::ACT_RAW;
  localparam logic [1:0] ACT_READ  = fabs_pkg::ACT_READ;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int RANDOM_PER_PHASE = 110;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [10:0] x;
    logic signed [10:0] y;
    logic [31:0]        src;
    logic [31:0]        raw;
  } pixel_req_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        in_bounds;
    logic        was_written;
  } pixel_rsp_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_SET_FORMAT, ROW_SET_STRIDE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [1:0]         action;
    logic signed [10:0] x;
    logic signed [10:0] y;
    logic [31:0]        src;
    logic [31:0]        raw;
    logic               typed;
    logic [31:0]        exp_word;
    logic               exp_inb;
    logic               exp_wr;
  } dir_row_t;

  typedef enum logic [1:0] {PH_NORMAL, PH_STEADY, PH_HOLD, PH_SHUFFLE} phase_mode_e;

  typedef struct packed {
    fabs_pkg::fmt_e fmt;
    logic [9:0]     stride;
    phase_mode_e    mode;
  } phase_t;

  // register rows carry their data in raw
  localparam dir_row_t DIRECTED_ROWS [26] = '{
    '{ROW_PIXEL, ACT_RAW, 11'sd0, 11'sd0, 32'h0, 32'hDEADBEEF, 1, 32'hDEADBEEF, 1, 1},
    '{ROW_PIXEL, ACT_READ, 11'sd0, 11'sd0, 32'h0, 32'h0, 1, 32'hDEADBEEF, 1, 0},
    '{ROW_PIXEL, ACT_BLEND, 11'sd479, 11'sd271, 32'hFF112233, 32'h0, 1, 32'h00112233, 1, 1},
    '{ROW_PIXEL, ACT_SPARE, 11'sd479, 11'sd271, 32'h0, 32'h0, 1, 32'h00112233, 1, 0},
    '{ROW_PIXEL, ACT_BLEND, 11'sd479, 11'sd271, 32'h00ABCDEF, 32'h0, 1, 32'h00112233, 1, 0},
    '{ROW_PIXEL, ACT_BLEND, 11'sd479, 11'sd271, 32'h80FFFFFF, 32'h0, 0, 32'h0, 0, 0},
    '{ROW_PIXEL, ACT_BLEND, 11'sd480, 11'sd0, 32'hFFFFFFFF, 32'h0, 1, 32'h0, 0, 0},
    '{ROW_PIXEL, ACT_RAW, -11'sd1, 11'sd0, 32'h0, 32'hFFFFFFFF, 1, 32'h0, 0, 0},
    '{ROW_PIXEL, ACT_READ, 11'sd0, 11'sd272, 32'h0, 32'h0, 1, 32'h0, 0, 0},
    '{ROW_PIXEL, ACT_READ, 11'h400, 11'h400, 32'h0, 32'h0, 1, 32'h0, 0, 0},
    '{ROW_PIXEL, ACT_RAW, 11'sd1023, 11'sd1023, 32'h0, 32'hFFFFFFFF, 1, 32'h0, 0, 0},
    '{ROW_PIXEL, ACT_BLEND, 11'sd0, -11'sd1, 32'hFF000000, 32'h0, 1, 32'h0, 0, 0},
    '{ROW_PIXEL, ACT_RAW, 11'sd0, 11'sd0, 32'h0, 32'h0, 1, 32'h0, 1, 1},
    '{ROW_PIXEL, ACT_RAW, 11'sd0, 11'sd0, 32'h0, 32'h0, 1, 32'h0, 1, 1},
    '{ROW_PIXEL, ACT_BLEND, 11'sd0, 11'sd0, 32'h01FFFFFF, 32'h0, 0, 32'h0, 0, 0},
    '{ROW_PIXEL, ACT_RAW, 11'sd1, 11'sd0, 32'h0, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1, 1},
    '{ROW_PIXEL, ACT_BLEND, 11'sd479, 11'sd271, 32'hFEFFFFFF, 32'h0, 0, 32'h0, 0, 0},
    '{ROW_PIXEL, ACT_BLEND, 11'sd479, 11'sd271, 32'h7F000000, 32'h0, 0, 32'h0, 0, 0},
    '{ROW_SET_FORMAT, ACT_READ, 11'sd0, 11'sd0, 32'h0, 32'(fabs_pkg::FMT_RGB565), 0, 32'h0, 0, 0},
    '{ROW_PIXEL, ACT_READ, 11'sd1, 11'sd0, 32'h0, 32'h0, 1, 32'h0000FFFF, 1, 0},
    '{ROW_PIXEL, ACT_RAW, 11'sd2, 11'sd0, 32'h0, 32'hABCD1234, 1, 32'h00001234, 1, 1},
    '{ROW_PIXEL, ACT_BLEND, 11'sd2, 11'sd0, 32'hFFFFFFFF, 32'h0, 1, 32'h0000FFFF, 1, 1},
    '{ROW_PIXEL, ACT_BLEND, 11'sd2, 11'sd0, 32'h80000000, 32'h0, 0, 32'h0, 0, 0},
    '{ROW_SET_STRIDE, ACT_READ, 11'sd0, 11'sd0, 32'h0, 32'd0, 0, 32'h0, 0, 0},
    '{ROW_PIXEL, ACT_READ, 11'sd2, 11'sd5, 32'h0, 32'h0, 0, 32'h0, 0, 0},
    '{ROW_SET_STRIDE, ACT_READ, 11'sd0, 11'sd0, 32'h0, 32'd512, 0, 32'h0, 0, 0}
  };

  localparam phase_t PHASES [10] = '{
    '{fabs_pkg::FMT_ABGR8888, 10'd512, PH_NORMAL},
    '{fabs_pkg::FMT_RGB565, 10'd480, PH_STEADY},
    '{fabs_pkg::FMT_RGB5551, 10'd1, PH_NORMAL},
    '{fabs_pkg::FMT_RGB4444, 10'd0, PH_NORMAL},
    '{fabs_pkg::FMT_ABGR8888, 10'd1023, PH_HOLD},
    '{fabs_pkg::FMT_RGB565, 10'd512, PH_NORMAL},
    '{fabs_pkg::FMT_RGB5551, 10'd511, PH_NORMAL},
    '{fabs_pkg::FMT_RGB4444, 10'd256, PH_NORMAL},
    '{fabs_pkg::FMT_ABGR8888, 10'd512, PH_SHUFFLE},
    '{fabs_pkg::FMT_RGB565, 10'd512, PH_SHUFFLE}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [fabs_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [fabs_pkg::CFG_DATA_W-1:0] cfg_data_i;

  fabs_req_if req_if ();
  fabs_rsp_if rsp_if ();

  framebuffer_alpha_blend_store dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  logic [31:0]    shadow_store [int];
  fabs_pkg::fmt_e cur_format = fabs_pkg::FMT_ABGR8888;
  logic [9:0]     cur_stride = 10'd512;
  pixel_rsp_t     expected_pixels [$];

  bit gaps_on = 1'b1;
  int hold_request = 0;
  int hold_left = 0;
  int mismatches = 0;
  int words_sent = 0;
  int on_screen_total = 0;
  int results_checked = 0;
  int settings_written = 0;
  int idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit on_screen(logic signed [10:0] x, logic signed [10:0] y);
    return x >= 0 && x < fabs_pkg::SCREEN_COLS && y >= 0 && y < fabs_pkg::SCREEN_ROWS;
  endfunction

  function automatic int store_addr(logic signed [10:0] x, logic signed [10:0] y);
    int stride;
    stride = (cur_stride > fabs_pkg::MAX_STRIDE) ? fabs_pkg::MAX_STRIDE : int'(cur_stride);
    return int'(x) + int'(y) * stride;
  endfunction

  function automatic fabs_pkg::rgb_t unpack_pixel(logic [31:0] w, fabs_pkg::fmt_e f);
    fabs_pkg::rgb_t c;
    case (f)
      fabs_pkg::FMT_RGB565: begin
        c.b = 8'(w[15:11]) << 3;
        c.g = 8'(w[10:5]) << 2;
        c.r = 8'(w[4:0]) << 3;
      end
      fabs_pkg::FMT_RGB5551: begin
        c.b = 8'(w[14:10]) << 3;
        c.g = 8'(w[9:5]) << 3;
        c.r = 8'(w[4:0]) << 3;
      end
      fabs_pkg::FMT_RGB4444: begin
        c.b = 8'(w[11:8]) << 4;
        c.g = 8'(w[7:4]) << 4;
        c.r = 8'(w[3:0]) << 4;
      end
      default: c = w[23:0];
    endcase
    return c;
  endfunction

  function automatic logic [31:0] pack_pixel(fabs_pkg::rgb_t c, fabs_pkg::fmt_e f);
    case (f)
      fabs_pkg::FMT_RGB565:
        return 32'(c.r >> 3) | (32'(c.g >> 2) << 5) | (32'(c.b >> 3) << 11);
      fabs_pkg::FMT_RGB5551:
        return 32'(c.r >> 3) | (32'(c.g >> 3) << 5) | (32'(c.b >> 3) << 10);
      fabs_pkg::FMT_RGB4444:
        return 32'(c.r >> 4) | (32'(c.g >> 4) << 4) | (32'(c.b >> 4) << 8);
      default:
        return 32'(c.r) | (32'(c.g) << 8) | (32'(c.b) << 16);
    endcase
  endfunction

  function automatic logic [7:0] blend_channel(int a, int s, int d);
    return 8'((a * s + (255 - a) * d) / 255);
  endfunction

  // source-over blend into the shadow store, returns what the block should answer
  function automatic pixel_rsp_t predict_pixel(pixel_req_t q);
    pixel_rsp_t     res;
    logic [31:0]    mask;
    logic [31:0]    word;
    logic [7:0]     a;
    fabs_pkg::rgb_t s;
    fabs_pkg::rgb_t d;
    fabs_pkg::rgb_t m;
    int             addr;
    bit             wrote;
    res = '0;
    wrote = 1'b0;
    if (!on_screen(q.x, q.y)) return res;
    res.in_bounds = 1'b1;
    addr = store_addr(q.x, q.y);
    if (addr >= fabs_pkg::STORE_DEPTH) return res;
    mask = (cur_format == fabs_pkg::FMT_ABGR8888) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    word = shadow_store.exists(addr) ? (shadow_store[addr] & mask) : 32'h0;
    a = q.src[31:24];
    s = q.src[23:0];
    if (q.action == ACT_BLEND) begin
      if (a == 8'hFF) begin
        word = pack_pixel(s, cur_format);
        wrote = 1'b1;
      end else if (a != 8'h00) begin
        d = unpack_pixel(word, cur_format);
        m.b = blend_channel(a, s.b, d.b);
        m.g = blend_channel(a, s.g, d.g);
        m.r = blend_channel(a, s.r, d.r);
        word = pack_pixel(m, cur_format);
        wrote = 1'b1;
      end
    end else if (q.action == ACT_RAW) begin
      word = q.raw & mask;
      wrote = 1'b1;
    end
    if (wrote) shadow_store[addr] = word;
    res.pixel_word = word & mask;
    res.was_written = wrote;
    return res;
  endfunction

  // mostly revisits of the screen corners so blends stack up on written pixels
  function automatic pixel_req_t random_pixel_req();
    pixel_req_t q;
    int         pick;
    bit         needs_old;
    q.src = $urandom;
    q.raw = $urandom;
    pick = $urandom_range(99);
    if (pick < 12) begin
      q.x = 11'($urandom);
      q.y = 11'($urandom);
    end else if (pick < 32) begin
      q.x = 11'($urandom_range(fabs_pkg::SCREEN_COLS - 1));
      q.y = 11'($urandom_range(fabs_pkg::SCREEN_ROWS - 1));
    end else begin
      q.x = 11'($urandom_range(7));
      q.y = 11'($urandom_range(3));
      if ($urandom_range(1)) q.x = 11'(fabs_pkg::SCREEN_COLS - 1) - q.x;
      if ($urandom_range(1)) q.y = 11'(fabs_pkg::SCREEN_ROWS - 1) - q.y;
    end
    pick = $urandom_range(99);
    if (pick < 45) q.action = ACT_BLEND;
    else if (pick < 70) q.action = ACT_RAW;
    else if (pick < 95) q.action = ACT_READ;
    else q.action = ACT_SPARE;
    pick = $urandom_range(99);
    if (pick < 20) q.src[31:24] = 8'h00;
    else if (pick < 40) q.src[31:24] = 8'hFF;
    else q.src[31:24] = 8'($urandom_range(1, 254));
    // a pixel never written must be written before anything reads it
    if (on_screen(q.x, q.y) && !shadow_store.exists(store_addr(q.x, q.y))) begin
      needs_old = !(q.action == ACT_RAW || (q.action == ACT_BLEND && q.src[31:24] == 8'hFF));
      if (needs_old) q.action = ACT_RAW;
    end
    return q;
  endfunction

  task automatic offer_pixel(pixel_req_t q, bit typed, pixel_rsp_t typed_rsp);
    pixel_rsp_t res;
    if (gaps_on && $urandom_range(99) < 28) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 28);
    end
    req_if.valid     <= 1'b1;
    req_if.action    <= q.action;
    req_if.pos_x     <= q.x;
    req_if.pos_y     <= q.y;
    req_if.src_color <= q.src;
    req_if.raw_pixel <= q.raw;
    do @(posedge clk_i); while (!req_if.ready);
    res = predict_pixel(q);
    expected_pixels.push_back(typed ? typed_rsp : res);
    words_sent++;
    if (on_screen(q.x, q.y)) on_screen_total++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(fabs_pkg::cfg_reg_e idx, logic [9:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fabs_pkg::CFG_PIXEL_FORMAT) cur_format = fabs_pkg::fmt_e'(data[1:0]);
    else cur_stride = data;
    settings_written++;
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (gaps_on) begin
        rsp_if.ready <= ($urandom_range(99) >= 28);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result word: pixel_word %h", rsp_if.pixel_word);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (rsp_if.pixel_word !== want.pixel_word) begin
          $error("pixel_word: expected %h, got %h", want.pixel_word, rsp_if.pixel_word);
          mismatches++;
        end
        if (rsp_if.in_bounds !== want.in_bounds) begin
          $error("in_bounds: expected %b, got %b", want.in_bounds, rsp_if.in_bounds);
          mismatches++;
        end
        if (rsp_if.was_written !== want.was_written) begin
          $error("was_written: expected %b, got %b", want.was_written, rsp_if.was_written);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("no word moved for %0d cycles", IDLE_LIMIT);
    $display("FAIL framebuffer_alpha_blend_store");
    $finish;
  end

  initial begin
    dir_row_t   row;
    phase_t     ph;
    pixel_req_t q;
    pixel_rsp_t typed_rsp;
    int         phase_count;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= fabs_pkg::CFG_PIXEL_FORMAT;
    cfg_data_i       <= '0;
    req_if.valid     <= 1'b0;
    req_if.action    <= ACT_READ;
    req_if.pos_x     <= '0;
    req_if.pos_y     <= '0;
    req_if.src_color <= '0;
    req_if.raw_pixel <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      case (row.kind)
        ROW_SET_FORMAT: write_reg(fabs_pkg::CFG_PIXEL_FORMAT, row.raw[9:0]);
        ROW_SET_STRIDE: write_reg(fabs_pkg::CFG_LINE_STRIDE, row.raw[9:0]);
        default: begin
          q.action = row.action;
          q.x = row.x;
          q.y = row.y;
          q.src = row.src;
          q.raw = row.raw;
          typed_rsp.pixel_word = row.exp_word;
          typed_rsp.in_bounds = row.exp_inb;
          typed_rsp.was_written = row.exp_wr;
          offer_pixel(q, row.typed, typed_rsp);
        end
      endcase
    end

    foreach (PHASES[p]) begin
      ph = PHASES[p];
      if (ph.mode == PH_SHUFFLE) begin
        ph.fmt = fabs_pkg::fmt_e'($urandom_range(3));
        ph.stride = 10'($urandom_range(1023));
      end
      // upper data bits of the format write are don't-care
      write_reg(fabs_pkg::CFG_PIXEL_FORMAT, {8'($urandom), ph.fmt});
      write_reg(fabs_pkg::CFG_LINE_STRIDE, ph.stride);
      gaps_on = (ph.mode != PH_STEADY && ph.mode != PH_HOLD);
      if (ph.mode == PH_HOLD) hold_request = HOLD_CYCLES;
      phase_count = 0;
      while (phase_count < RANDOM_PER_PHASE) begin
        q = random_pixel_req();
        offer_pixel(q, 1'b0, '0);
        phase_count++;
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("%0d words sent, %0d on screen, %0d results checked",
             words_sent, on_screen_total, results_checked);
    $display("%0d register writes over all four formats and strides from 0 to 1023",
             settings_written);
    if (mismatches == 0) begin
      $display("PASS framebuffer_alpha_blend_store");
    end else begin
      $display("FAIL framebuffer_alpha_blend_store");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fabs_pkg.sv
rtl/fabs_if.sv
rtl/framebuffer_alpha_blend_store.sv
verif/tb_framebuffer_alpha_blend_store.sv
